// ===== hdl/lzw_pkg.sv =====
// lzw_pkg: shared constants, state encoding and control structs of the lzw compressor
// no dependencies; compiled before every other file of the block

package lzw_pkg;

  // code width default and fixed byte geometry
  localparam int LZW_CODE_WIDTH = 9;
  localparam int LZW_BYTE_W     = 8;
  localparam int LZW_FIRST_FREE = 256;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SEARCH,
    ST_MISS,
    ST_FINAL
  } lzw_state_t;

  // controller to cell row
  typedef struct packed {
    logic launch;
    logic wr_en;
  } lzw_chain_cmd_t;

  // cell row to controller
  typedef struct packed {
    logic done;
    logic hit;
  } lzw_chain_sts_t;

endpackage

// ===== hdl/lzw_in_if.sv =====
// lzw_in_if: input channel of the lzw compressor, one message byte per word
// depends on lzw_pkg

interface lzw_in_if import lzw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LZW_BYTE_W-1:0] in_byte;
  logic                  in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

// ===== hdl/lzw_out_if.sv =====
// lzw_out_if: result channel of the lzw compressor, one code per word
// depends on lzw_pkg

interface lzw_out_if import lzw_pkg::*; #(
  parameter int CODE_WIDTH = LZW_CODE_WIDTH
) ();
  logic                  valid;
  logic                  ready;
  logic [CODE_WIDTH-1:0] out_code;
  logic                  out_last;

  modport source (output valid, out_code, out_last, input ready);
  modport sink   (input valid, out_code, out_last, output ready);
endinterface

// ===== hdl/lzw_cell.sv =====
// lzw_cell: one dictionary entry of the cell row, with its compare and token stage
// depends on lzw_pkg

module lzw_cell import lzw_pkg::*; #(
  parameter int CODE_WIDTH = LZW_CODE_WIDTH,
  parameter int IDX_W      = LZW_CODE_WIDTH,
  parameter int CELL_IDX   = 0,
  parameter int CELL_CODE  = LZW_FIRST_FREE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lzw_chain_cmd_t                   cmd,
  input  logic [IDX_W-1:0]                 start_idx,
  input  logic [IDX_W-1:0]                 wr_idx,
  input  logic [CODE_WIDTH+LZW_BYTE_W-1:0] key,
  input  logic                             prev_valid,
  input  logic                             prev_hit,
  input  logic [CODE_WIDTH-1:0]            prev_code,
  output logic                             tok_valid,
  output logic                             tok_hit,
  output logic [CODE_WIDTH-1:0]            tok_code
);

  localparam int KEY_W = CODE_WIDTH + LZW_BYTE_W;

  logic [KEY_W-1:0]      entry_r;
  logic                  valid_r;
  logic                  hit_r;
  logic [CODE_WIDTH-1:0] code_r;
  logic                  valid_nxt;
  logic                  hit_nxt;
  logic [CODE_WIDTH-1:0] code_nxt;
  logic                  inject;
  logic                  match;
  logic                  base_hit;
  logic [CODE_WIDTH-1:0] base_code;

  // a search starts at the newest live entry's cell
  assign inject = cmd.launch && (start_idx == IDX_W'(CELL_IDX));
  assign match  = (entry_r == key);

  // token merge: keep an earlier hit, else take this cell's code
  always_comb begin
    base_hit  = inject ? 1'b0 : prev_hit;
    base_code = inject ? '0 : prev_code;
    valid_nxt = inject | prev_valid;
    hit_nxt   = base_hit | match;
    code_nxt  = (match && !base_hit) ? CODE_WIDTH'(CELL_CODE) : base_code;
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    hit_r  <= hit_nxt;
    code_r <= code_nxt;
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      entry_r <= key;
    end
  end

  assign tok_valid = valid_r;
  assign tok_hit   = hit_r;
  assign tok_code  = code_r;

endmodule

// ===== hdl/lzw_chain.sv =====
// lzw_chain: row of dictionary cells; a search token walks one cell per cycle to the tail
// depends on lzw_pkg and lzw_cell

module lzw_chain import lzw_pkg::*; #(
  parameter int CODE_WIDTH = LZW_CODE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lzw_chain_cmd_t                       cmd,
  input  logic [$clog2((1 << CODE_WIDTH) - LZW_FIRST_FREE)-1:0] start_idx,
  input  logic [$clog2((1 << CODE_WIDTH) - LZW_FIRST_FREE)-1:0] wr_idx,
  input  logic [CODE_WIDTH+LZW_BYTE_W-1:0]     key,
  output lzw_chain_sts_t                       sts,
  output logic [CODE_WIDTH-1:0]                hit_code
);

  localparam int CODE_LIMIT = 1 << CODE_WIDTH;
  localparam int DEPTH      = CODE_LIMIT - LZW_FIRST_FREE;
  localparam int IDX_W      = $clog2(DEPTH);

  logic [DEPTH-1:0]      tok_valid;
  logic [DEPTH-1:0]      tok_hit;
  logic [CODE_WIDTH-1:0] tok_code [DEPTH];

  // cell j holds the entry for code CODE_LIMIT-1-j, newest entries nearest the head
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      lzw_cell #(
        .CODE_WIDTH (CODE_WIDTH),
        .IDX_W      (IDX_W),
        .CELL_IDX   (j),
        .CELL_CODE  (CODE_LIMIT - 1 - j)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .start_idx  (start_idx),
        .wr_idx     (wr_idx),
        .key        (key),
        .prev_valid (1'b0),
        .prev_hit   (1'b0),
        .prev_code  ('0),
        .tok_valid  (tok_valid[j]),
        .tok_hit    (tok_hit[j]),
        .tok_code   (tok_code[j])
      );
    end else begin : g_body
      lzw_cell #(
        .CODE_WIDTH (CODE_WIDTH),
        .IDX_W      (IDX_W),
        .CELL_IDX   (j),
        .CELL_CODE  (CODE_LIMIT - 1 - j)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .start_idx  (start_idx),
        .wr_idx     (wr_idx),
        .key        (key),
        .prev_valid (tok_valid[j-1]),
        .prev_hit   (tok_hit[j-1]),
        .prev_code  (tok_code[j-1]),
        .tok_valid  (tok_valid[j]),
        .tok_hit    (tok_hit[j]),
        .tok_code   (tok_code[j])
      );
    end
  end

  // tail of the row reports the search outcome
  assign sts.done = tok_valid[DEPTH-1];
  assign sts.hit  = tok_hit[DEPTH-1];
  assign hit_code = tok_code[DEPTH-1];

`ifndef SYNTHESIS
  // at most one search token in flight along the row
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid))
    else $error("more than one search token in the cell row");
`endif

endmodule

// ===== hdl/lzw_ctrl.sv =====
// lzw_ctrl: message sequencer; holds prefix and next free code, drives searches and inserts
// depends on lzw_pkg

module lzw_ctrl import lzw_pkg::*; #(
  parameter int CODE_WIDTH = LZW_CODE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [LZW_BYTE_W-1:0]                in_byte,
  input  logic                                 in_last,
  input  logic                                 out_free,
  output logic                                 out_load,
  output logic [CODE_WIDTH-1:0]                out_code,
  output logic                                 out_last,
  output lzw_chain_cmd_t                       cmd,
  output logic [$clog2((1 << CODE_WIDTH) - LZW_FIRST_FREE)-1:0] start_idx,
  output logic [$clog2((1 << CODE_WIDTH) - LZW_FIRST_FREE)-1:0] wr_idx,
  output logic [CODE_WIDTH+LZW_BYTE_W-1:0]     key,
  input  lzw_chain_sts_t                       sts,
  input  logic [CODE_WIDTH-1:0]                hit_code
);

  localparam int CODE_LIMIT = 1 << CODE_WIDTH;
  localparam int DEPTH      = CODE_LIMIT - LZW_FIRST_FREE;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int NFC_W      = CODE_WIDTH + 1;

  lzw_state_t            state_r, state_nxt;
  logic [CODE_WIDTH-1:0] prefix_code_r, prefix_code_nxt;
  logic                  prefix_valid_r, prefix_valid_nxt;
  logic [NFC_W-1:0]      next_free_r, next_free_nxt;
  logic [LZW_BYTE_W-1:0] byte_r;
  logic                  last_r;
  logic                  accept;
  logic                  dict_empty;
  logic                  dict_full;
  logic [NFC_W-1:0]      start_full;
  logic [NFC_W-1:0]      wr_full;

  assign accept     = in_valid && in_ready;
  assign dict_empty = (next_free_r == NFC_W'(LZW_FIRST_FREE));
  assign dict_full  = next_free_r[CODE_WIDTH];

  // newest live entry sits at cell CODE_LIMIT-next_free, the next insert one cell nearer the head
  assign start_full = NFC_W'(CODE_LIMIT) - next_free_r;
  assign wr_full    = start_full - NFC_W'(1);
  assign start_idx  = start_full[IDX_W-1:0];
  assign wr_idx     = wr_full[IDX_W-1:0];
  assign key        = {prefix_code_r, byte_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (!prefix_valid_r) state_nxt = last_r ? ST_FINAL : ST_IDLE;
        else if (dict_empty) state_nxt = ST_MISS;
        else                 state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.done) begin
          if (sts.hit) state_nxt = last_r ? ST_FINAL : ST_IDLE;
          else         state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        if (out_free) state_nxt = last_r ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    out_last   = 1'b0;
    cmd.launch = 1'b0;
    cmd.wr_en  = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready   = 1'b1;
      ST_LAUNCH: cmd.launch = prefix_valid_r && !dict_empty;
      ST_SEARCH: ;
      ST_MISS: begin
        out_load  = out_free;
        cmd.wr_en = out_free && !dict_full;
      end
      ST_FINAL: begin
        out_load = out_free;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_code = prefix_code_r;

  // prefix and free code updates
  always_comb begin
    prefix_code_nxt  = prefix_code_r;
    prefix_valid_nxt = prefix_valid_r;
    next_free_nxt    = next_free_r;
    case (state_r)
      ST_LAUNCH: begin
        if (!prefix_valid_r) begin
          prefix_code_nxt  = CODE_WIDTH'(byte_r);
          prefix_valid_nxt = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (sts.done && sts.hit) prefix_code_nxt = hit_code;
      end
      ST_MISS: begin
        if (out_free) begin
          prefix_code_nxt = CODE_WIDTH'(byte_r);
          if (!dict_full) next_free_nxt = next_free_r + NFC_W'(1);
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          prefix_code_nxt  = '0;
          prefix_valid_nxt = 1'b0;
          next_free_nxt    = NFC_W'(LZW_FIRST_FREE);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      prefix_code_r  <= '0;
      prefix_valid_r <= 1'b0;
      next_free_r    <= NFC_W'(LZW_FIRST_FREE);
    end else begin
      state_r        <= state_nxt;
      prefix_code_r  <= prefix_code_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      next_free_r    <= next_free_nxt;
    end
  end

  // captured input word
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

`ifndef SYNTHESIS
  // a search is never started over an empty dictionary
  a_launch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.launch |-> !dict_empty)
    else $error("search launched with no dictionary entries");

  // no insert once every code is taken
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !dict_full)
    else $error("dictionary insert beyond the last code");

  // the row only reports while a search is pending
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == ST_SEARCH))
    else $error("search result outside a search");

  // a launch is always followed by the wait for its result
  a_launch_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.launch |=> (state_r == ST_SEARCH))
    else $error("search launched without waiting for it");
`endif

endmodule

// ===== hdl/lzw_compressor.sv =====
// lzw_compressor: top level of the lzw encoder with fixed-width codes and its output register
// depends on lzw_pkg, lzw_in_if, lzw_out_if, lzw_ctrl and lzw_chain
//
// Usage:
//   in_ch carries one message byte per word (in_byte) with in_last marking the final byte.
//   out_ch carries one CODE_WIDTH-bit code per word with out_last on the final code.
//   Each byte yields zero, one or two codes; the first byte yields none unless it is the last.
//   The dictionary is a row of 2**CODE_WIDTH-256 cells; a search token enters at the
//   newest live entry and steps one cell per clock to the tail, so a search takes longer
//   the more entries are live; a byte that opens a message or misses an empty dictionary
//   is not searched at all, and the last byte also passes through a state for the final code.
//   in_ch.ready is high only while the block waits for a byte.
//   A code sits in an output register; the next byte is taken while it waits there.
//   When the receiver stalls with a code still held, the block waits before loading
//   the next code and keeps in_ch.ready low meanwhile.
//   After the final code of a message the prefix and free code counter return to their
//   reset values, which empties the dictionary for the next message.
//   Reset (rst_n low, synchronous) empties the dictionary, clears the output register
//   and leaves the block ready for the first byte; no clearing pass is needed.

module lzw_compressor import lzw_pkg::*; #(
  parameter int CODE_WIDTH = LZW_CODE_WIDTH
) (
  input  logic    clk,
  input  logic    rst_n,
  lzw_in_if.sink  in_ch,
  lzw_out_if.source out_ch
);

  localparam int DEPTH = (1 << CODE_WIDTH) - LZW_FIRST_FREE;
  localparam int IDX_W = $clog2(DEPTH);

  lzw_chain_cmd_t                  cmd;
  lzw_chain_sts_t                  sts;
  logic [IDX_W-1:0]                start_idx;
  logic [IDX_W-1:0]                wr_idx;
  logic [CODE_WIDTH+LZW_BYTE_W-1:0] key;
  logic [CODE_WIDTH-1:0]           hit_code;
  logic                            out_free;
  logic                            out_load;
  logic [CODE_WIDTH-1:0]           load_code;
  logic                            load_last;
  logic                            out_valid_r;
  logic [CODE_WIDTH-1:0]           out_code_r;
  logic                            out_last_r;

  lzw_ctrl #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_code  (load_code),
    .out_last  (load_last),
    .cmd       (cmd),
    .start_idx (start_idx),
    .wr_idx    (wr_idx),
    .key       (key),
    .sts       (sts),
    .hit_code  (hit_code)
  );

  lzw_chain #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .start_idx (start_idx),
    .wr_idx    (wr_idx),
    .key       (key),
    .sts       (sts),
    .hit_code  (hit_code)
  );

  // output register frees when empty or being taken
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= load_code;
      out_last_r <= load_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_code = out_code_r;
  assign out_ch.out_last = out_last_r;

endmodule

// ===== sim/lzw_code_checker.sv =====
// lzw_code_checker: watches both channels of the lzw compressor, predicts every code word
// and compares it with what the block delivers; depends on lzw_pkg

module lzw_code_checker import lzw_pkg::*; #(
  parameter int CODE_WIDTH = LZW_CODE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [LZW_BYTE_W-1:0] in_byte,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CODE_WIDTH-1:0] out_code,
  input  logic                  out_last,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_SPAN  = 1 << CODE_WIDTH;
  localparam int DICT_DEPTH = CODE_SPAN - LZW_FIRST_FREE;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] code;
    logic                  last;
  } code_word_t;

  // predicted encoder state
  logic [CODE_WIDTH+LZW_BYTE_W-1:0] pair_tab [DICT_DEPTH];
  logic [CODE_WIDTH-1:0]            cur_prefix;
  logic                             have_prefix;
  logic [CODE_WIDTH:0]              free_code;

  code_word_t code_q [$];
  int         err_count = 0;

  task automatic clear_encoder();
    cur_prefix  = '0;
    have_prefix = 1'b0;
    free_code   = (CODE_WIDTH+1)'(LZW_FIRST_FREE);
  endtask

  // one byte through the encoder, expected code words go to the queue
  task automatic encode_byte(input logic [LZW_BYTE_W-1:0] b, input logic l);
    logic [CODE_WIDTH+LZW_BYTE_W-1:0] key;
    logic [CODE_WIDTH-1:0]            hit_code;
    logic                             hit;
    int                               used;
    code_word_t                       exp_word;
    if (!have_prefix) begin
      cur_prefix  = CODE_WIDTH'(b);
      have_prefix = 1'b1;
    end else begin
      key      = {cur_prefix, b};
      used     = int'(free_code) - LZW_FIRST_FREE;
      hit      = 1'b0;
      hit_code = '0;
      for (int k = 0; k < used; k++) begin
        if (!hit && pair_tab[k] == key) begin
          hit      = 1'b1;
          hit_code = CODE_WIDTH'(LZW_FIRST_FREE + k);
        end
      end
      if (hit) begin
        cur_prefix = hit_code;
      end else begin
        exp_word.code = cur_prefix;
        exp_word.last = 1'b0;
        code_q = {code_q, exp_word};
        // a full dictionary takes no new pair
        if (int'(free_code) < CODE_SPAN) begin
          pair_tab[int'(free_code) - LZW_FIRST_FREE] = key;
          free_code = free_code + 1'b1;
        end
        cur_prefix = CODE_WIDTH'(b);
      end
    end
    // final prefix closes the message
    if (l) begin
      exp_word.code = cur_prefix;
      exp_word.last = 1'b1;
      code_q = {code_q, exp_word};
      clear_encoder();
    end
  endtask

  // compare delivered words first, then take in the accepted byte
  always @(posedge clk) begin
    code_word_t want;
    if (!rst_n) begin
      clear_encoder();
      code_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (code_q.size() == 0) begin
          $error("unexpected word: out_code %0d out_last %0b", out_code, out_last);
          err_count++;
        end else begin
          want = code_q.pop_front();
          if (out_code !== want.code) begin
            $error("out_code: expected %0d, actual %0d", want.code, out_code);
            err_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) encode_byte(in_byte, in_last);
      pending <= code_q.size();
    end
    mismatches <= err_count;
  end

endmodule

// ===== sim/tb_lzw_compressor.sv =====
// tb_lzw_compressor: stimulus, idling and verdict for the lzw compressor
// depends on lzw_pkg, lzw_in_if, lzw_out_if, lzw_compressor and lzw_code_checker

module tb_lzw_compressor;
  timeunit 1ns;
  timeprecision 1ps;
  import lzw_pkg::*;

  localparam int CODE_W         = LZW_CODE_WIDTH;
  localparam int BYTE_TARGET    = 1450;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lzw_in_if                       in_ch ();
  lzw_out_if #(.CODE_WIDTH(CODE_W)) out_ch ();

  int mismatches;
  int pending;

  int src_idle_pct = 35;
  int snk_idle_pct = 80;
  int hold_asks    = 0;
  int hold_done    = 0;
  int bytes_sent   = 0;
  int msgs_sent    = 0;
  int quiet_cycles = 0;

  lzw_compressor #(.CODE_WIDTH(CODE_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lzw_code_checker #(.CODE_WIDTH(CODE_W)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .in_last    (in_ch.in_last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_code   (out_ch.out_code),
    .out_last   (out_ch.out_last),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random ready, or a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_done + 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one byte after an optional gap, return once it is taken
  task automatic send_byte(input logic [LZW_BYTE_W-1:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (l) msgs_sent++;
  endtask

  // a message drawn from a small alphabet, or from all bytes
  task automatic send_message(input int len, input int alpha);
    logic [LZW_BYTE_W-1:0] base;
    logic [LZW_BYTE_W-1:0] b;
    base = LZW_BYTE_W'($urandom_range(255));
    for (int i = 0; i < len; i++) begin
      if (alpha >= 256) b = LZW_BYTE_W'($urandom_range(255));
      else b = base + LZW_BYTE_W'($urandom_range(alpha - 1));
      send_byte(b, i == len - 1);
    end
  endtask

  // sender stops until every predicted word has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int new_phase;
    int msg_idx;
    int len;
    int alpha;
    int r;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-byte messages at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // repeated byte, prefix grows through the dictionary
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    // alternating extremes
    for (int i = 0; i < 6; i++) send_byte((i % 2) ? 8'hff : 8'h00, i == 5);
    // opening byte, then a miss on the last byte
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);
    // pair pattern with hits on longer strings
    for (int i = 0; i < 7; i++) send_byte((i % 2) ? 8'h43 : 8'h42, i == 6);

    // random messages over three idling phases
    phase   = 0;
    msg_idx = 0;
    while (bytes_sent < BYTE_TARGET) begin
      new_phase = (bytes_sent < BYTE_TARGET / 3) ? 0 :
                  (bytes_sent < 2 * BYTE_TARGET / 3) ? 1 : 2;
      if (new_phase != phase) begin
        wait_drained();
        phase = new_phase;
        src_idle_pct = (phase == 1) ? 80 : 0;
        snk_idle_pct <= (phase == 1) ? 35 : 0;
      end
      if (msg_idx == 20 || msg_idx == 50) begin
        // long random message, runs past a full dictionary
        send_message(320, 256);
      end else if (phase == 2 && hold_asks == 0) begin
        // receiver stalls while the sender keeps offering
        hold_asks <= hold_asks + 1;
        send_message(40, 256);
      end else begin
        r = $urandom_range(99);
        len = (r < 10) ? $urandom_range(60, 21) : $urandom_range(20, 1);
        case ($urandom_range(4))
          0: alpha = 1;
          1: alpha = 2;
          2: alpha = 4;
          3: alpha = 16;
          default: alpha = 256;
        endcase
        send_message(len, alpha);
      end
      msg_idx++;
    end

    // drain and let the block settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes in %0d messages over three idling phases",
             bytes_sent, msgs_sent);
    $display("with a long receiver stall, drain pauses and messages past a full dictionary");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
